// ----- sv/q16_fixed_point_arith_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Q16.16 arithmetic unit assertion macros
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef Q16_FIXED_POINT_ARITH_UNIT_ASSERT_SVH
`define Q16_FIXED_POINT_ARITH_UNIT_ASSERT_SVH

`ifndef SYNTH

// plain condition checked at every clock edge out of reset
`define Q16FX_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed: cond");

// same-cycle implication
`define Q16FX_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: ante -> cons");

`else

`define Q16FX_ASSERT(lbl, cond)
`define Q16FX_ASSERT_IMP(lbl, ante, cons)

`endif

`endif

// ----- sv/q16fx_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Q16.16 arithmetic unit package
// Shared widths, operation and status codes and item types.
// ----------------------------------------------------------------------------
package q16fx_pkg;

	// fraction bits of the fixed-point format
	localparam int F = 16;
	// quotient width: 32-bit dividend shifted by up to F+8
	localparam int QW = 32 + F + 8;
	// width of the signed rounded-divide numerator
	localparam int NW = QW + 2;

	// operation codes
	localparam logic [2:0] OP_MUL    = 3'd0;
	localparam logic [2:0] OP_DIV    = 3'd1;
	localparam logic [2:0] OP_DOT    = 3'd2;
	localparam logic [2:0] OP_RDIV   = 3'd3;
	localparam logic [2:0] OP_DIV256 = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DIV0 = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;

	typedef struct packed {
		logic [2:0]         operation;
		logic signed [31:0] op_a;
		logic signed [31:0] op_b;
		logic signed [31:0] op_c;
		logic signed [31:0] op_d;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] result;
		logic [1:0]         status;
	} out_item_t;

	// side information that rides along with the divider
	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] mres;
		logic [1:0]  mstat;
		logic        div0;
		logic        neg;
	} tag_t;

endpackage

// ----- sv/q16fx_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Q16.16 pipelined divider
// Unsigned restoring division, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module q16fx_div
	import q16fx_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [QW-1:0] num,
	input  logic [31:0]   den,
	input  tag_t          tag_in,
	output logic          out_valid,
	output logic [QW-1:0] quo,
	output tag_t          tag_out
);

	logic          v_s   [QW];
	logic [QW-1:0] num_s [QW];
	logic [31:0]   den_s [QW];
	logic [31:0]   rem_s [QW];
	logic [QW-1:0] quo_s [QW];
	tag_t          tag_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stg
		logic          v_i;
		logic [QW-1:0] num_i;
		logic [31:0]   den_i;
		logic [31:0]   rem_i;
		logic [QW-1:0] quo_i;
		tag_t          tag_i;
		logic [32:0]   trial;
		logic [32:0]   diff;
		logic          ge;

		// stage inputs: port for the first stage, previous stage otherwise
		if (k == 0) begin : g_first
			assign v_i   = in_valid;
			assign num_i = num;
			assign den_i = den;
			assign rem_i = '0;
			assign quo_i = '0;
			assign tag_i = tag_in;
		end else begin : g_next
			assign v_i   = v_s[k-1];
			assign num_i = num_s[k-1];
			assign den_i = den_s[k-1];
			assign rem_i = rem_s[k-1];
			assign quo_i = quo_s[k-1];
			assign tag_i = tag_s[k-1];
		end

		// trial subtract of the divisor from the shifted remainder
		assign trial = {rem_i, num_i[QW-1]};
		assign diff  = trial - {1'b0, den_i};
		assign ge    = (trial >= {1'b0, den_i});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[k] <= num_i << 1;
				den_s[k] <= den_i;
				rem_s[k] <= ge ? diff[31:0] : trial[31:0];
				quo_s[k] <= {quo_i[QW-2:0], ge};
				tag_s[k] <= tag_i;
			end
		end
	end

	assign out_valid = v_s[QW-1];
	assign quo       = quo_s[QW-1];
	assign tag_out   = tag_s[QW-1];

endmodule

// ----- sv/q16_fixed_point_arith_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Q16.16 fixed-point arithmetic unit
// Rounded multiply, dot product and three divide forms, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  valid      stall      payload
//  in       op_valid   op_stall   op_item  (in_item_t)
//  out      res_valid  res_stall  res_item (out_item_t)
//
// One item enters per cycle unless a result is held; the divider resolves
// one quotient bit per stage.
// Multiply and dot-product results ride alongside the divider stages.
// Reset clears only the stage valid bits.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
module q16_fixed_point_arith_unit
	import q16fx_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      op_valid,
	output logic      op_stall,
	input  in_item_t  op_item,
	output logic      res_valid,
	input  logic      res_stall,
	output out_item_t res_item
);

`include "q16_fixed_point_arith_unit_assert.svh"

	localparam logic signed [64:0] RND     = 65'sd1 <<< (F - 1);
	localparam logic [QW-1:0]      LIM_POS = QW'(32'h7FFF_FFFF);
	localparam logic [QW-1:0]      LIM_NEG = QW'(32'h8000_0000);

	logic en;

	// stage 1 registers
	logic               v_s1;
	logic [2:0]         op_s1;
	logic signed [31:0] a_s1;
	logic signed [31:0] b_s1;
	logic signed [63:0] p1_s1;
	logic signed [63:0] p2_s1;
	logic signed [NW-1:0] n3_s1;

	// stage 2 registers
	logic          v_s2;
	logic [QW-1:0] num_s2;
	logic [31:0]   den_s2;
	tag_t          tag_s2;

	// divider outputs
	logic          div_valid;
	logic [QW-1:0] div_quo;
	tag_t          div_tag;

	// output register
	logic      res_valid_q;
	out_item_t res_q;

	// whole pipeline advances unless a result is held
	assign en       = !(res_valid_q && res_stall);
	assign op_stall = !en;

	// stage 1: products and signed rounded-divide numerator
	logic signed [NW-1:0] ax;
	logic signed [NW-1:0] hx;
	assign ax = NW'(op_item.op_a) <<< F;
	assign hx = NW'(op_item.op_b >>> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= op_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= op_item.operation;
			a_s1  <= op_item.op_a;
			b_s1  <= op_item.op_b;
			p1_s1 <= 64'(op_item.op_a) * 64'(op_item.op_b);
			p2_s1 <= 64'(op_item.op_c) * 64'(op_item.op_d);
			n3_s1 <= op_item.op_a[31] ? (ax - hx) : (ax + hx);
		end
	end

	// stage 2: multiply result, divider operands
	logic signed [64:0] addend;
	logic signed [64:0] msum;
	logic signed [64:0] mshift;
	logic [33:0]        mhi;
	logic [31:0]        amag;
	logic [NW-1:0]      n3mag;
	logic               bzero;
	logic               is_div;
	logic [QW-1:0]      num_d;
	logic               neg_d;
	tag_t               tag_d;

	assign addend = (op_s1 == OP_DOT) ? 65'(p2_s1) : RND;
	assign msum   = 65'(p1_s1) + addend;
	assign mshift = msum >>> F;
	assign mhi    = mshift[64:31];
	assign amag   = a_s1[31] ? 32'(-a_s1) : 32'(a_s1);
	assign n3mag  = n3_s1[NW-1] ? NW'(-n3_s1) : NW'(n3_s1);
	assign bzero  = (b_s1 == 32'sd0);
	assign is_div = (op_s1 == OP_DIV) || (op_s1 == OP_RDIV) || (op_s1 == OP_DIV256);

	always_comb begin
		case (op_s1)
			OP_RDIV: begin
				num_d = n3mag[QW-1:0];
				neg_d = n3_s1[NW-1] ^ b_s1[31];
			end
			OP_DIV256: begin
				num_d = QW'(amag) << (F + 8);
				neg_d = a_s1[31] ^ b_s1[31];
			end
			default: begin
				num_d = QW'(amag) << F;
				neg_d = a_s1[31] ^ b_s1[31];
			end
		endcase
		tag_d.op    = op_s1;
		tag_d.mres  = mshift[31:0];
		tag_d.mstat = ((&mhi) || !(|mhi)) ? ST_OK : ST_OVF;
		tag_d.div0  = is_div && bzero;
		tag_d.neg   = neg_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2 <= num_d;
			den_s2 <= bzero ? 32'd1 : (b_s1[31] ? 32'(-b_s1) : 32'(b_s1));
			tag_s2 <= tag_d;
		end
	end

	// divider stages
	q16fx_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.num       (num_s2),
		.den       (den_s2),
		.tag_in    (tag_s2),
		.out_valid (div_valid),
		.quo       (div_quo),
		.tag_out   (div_tag)
	);

	// final select: sign, overflow and operation
	logic [QW-1:0] qsigned;
	logic          qovf;
	out_item_t     res_d;

	assign qsigned = div_tag.neg ? (-div_quo) : div_quo;
	assign qovf    = div_tag.neg ? (div_quo > LIM_NEG) : (div_quo > LIM_POS);

	always_comb begin
		case (div_tag.op) inside
			OP_MUL, OP_DOT: begin
				res_d.result = div_tag.mres;
				res_d.status = div_tag.mstat;
			end
			OP_DIV, OP_RDIV, OP_DIV256: begin
				if (div_tag.div0) begin
					res_d.result = 32'sd0;
					res_d.status = ST_DIV0;
				end else begin
					res_d.result = qsigned[31:0];
					res_d.status = qovf ? ST_OVF : ST_OK;
				end
			end
			default: begin
				res_d.result = 32'sd0;
				res_d.status = ST_OK;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	// checks
	`Q16FX_ASSERT_IMP(a_hold_stalls_in, res_valid && res_stall, op_stall)
	`Q16FX_ASSERT_IMP(a_div0_zero, res_valid && (res_item.status == ST_DIV0), res_item.result == 32'sd0)
	`Q16FX_ASSERT_IMP(a_freeze_div, !en, ##1 $stable(div_valid))
	`Q16FX_ASSERT_IMP(a_div0_only_div, div_valid && div_tag.div0, div_tag.op != OP_MUL && div_tag.op != OP_DOT)

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Q16.16 arithmetic unit testbench
// Drives operation items through the unit with random idling on both sides,
// predicts each result from the operands and compares result and status in
// order of arrival.
// ----------------------------------------------------------------------------

// expected results in arrival order
class fx_scoreboard;
	q16fx_pkg::out_item_t pending[$];
	int unsigned n_fail;
	int unsigned n_mismatch;

	// low 32 bits plus overflow flag of an exact signed value
	static function q16fx_pkg::out_item_t wrap_signed(logic signed [127:0] v);
		q16fx_pkg::out_item_t r;
		r.result = v[31:0];
		r.status = (v < -128'sd2147483648 || v > 128'sd2147483647) ?
			q16fx_pkg::ST_OVF : q16fx_pkg::ST_OK;
		return r;
	endfunction

	// truncating divide of the operand pair, dividend shifted
	static function q16fx_pkg::out_item_t shift_quot(logic signed [127:0] a,
		logic signed [127:0] b, int sh);
		logic signed [127:0] n;
		n = a <<< sh;
		return wrap_signed(n / b);
	endfunction

	static function q16fx_pkg::out_item_t compute(q16fx_pkg::in_item_t it);
		q16fx_pkg::out_item_t r;
		logic signed [127:0] a, b, c, d, p, h;
		a = it.op_a;
		b = it.op_b;
		c = it.op_c;
		d = it.op_d;
		r.result = '0;
		r.status = q16fx_pkg::ST_OK;
		case (it.operation) inside
			q16fx_pkg::OP_MUL: begin
				p = a * b + (128'sd1 <<< (q16fx_pkg::F - 1));
				r = wrap_signed(p >>> q16fx_pkg::F);
			end
			q16fx_pkg::OP_DOT: begin
				p = a * b + c * d;
				r = wrap_signed(p >>> q16fx_pkg::F);
			end
			q16fx_pkg::OP_DIV, q16fx_pkg::OP_RDIV, q16fx_pkg::OP_DIV256: begin
				if (b == 0) begin
					r.status = q16fx_pkg::ST_DIV0;
				end else if (it.operation == q16fx_pkg::OP_DIV) begin
					r = shift_quot(a, b, q16fx_pkg::F);
				end else if (it.operation == q16fx_pkg::OP_DIV256) begin
					r = shift_quot(a, b, q16fx_pkg::F + 8);
				end else begin
					// half divisor floored, sign follows the dividend
					h = b >>> 1;
					p = a <<< q16fx_pkg::F;
					p = (a < 0) ? p - h : p + h;
					r = wrap_signed(p / b);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function void note_operation(q16fx_pkg::in_item_t it);
		pending.push_back(compute(it));
	endfunction

	function void check_result(q16fx_pkg::out_item_t got);
		q16fx_pkg::out_item_t want;
		if (pending.size() == 0) begin
			n_fail++;
			n_mismatch++;
			if (n_mismatch <= 10)
				$display("unexpected result %h status %0d", got.result, got.status);
			return;
		end
		want = pending.pop_front();
		if (got.result !== want.result || got.status !== want.status) begin
			n_fail++;
			n_mismatch++;
			if (n_mismatch <= 10)
				$display("mismatch: expected %h/%0d actual %h/%0d",
					want.result, want.status, got.result, got.status);
		end
	endfunction
endclass

module tb_top;
	import q16fx_pkg::*;

	localparam int LATENCY   = QW + 3;
	localparam int MAX_CYCLE = 400000;
	localparam int unsigned HOLD_LEN = 200;

	logic      clk;
	logic      arst_n;
	logic      op_valid;
	logic      op_stall;
	in_item_t  op_item;
	logic      res_valid;
	logic      res_stall;
	out_item_t res_item;

	fx_scoreboard board;
	int unsigned  send_idle_pct;
	int unsigned  recv_idle_pct;
	logic         hold_go;
	logic         hold_done;
	int unsigned  hold_cnt;
	longint       cycle;

	q16_fixed_point_arith_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op_stall  (op_stall),
		.op_item   (op_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// cycle limit
	initial begin
		cycle = 0;
		forever begin
			@(posedge clk);
			cycle++;
			if (cycle > MAX_CYCLE) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// receiver: random stall, one long hold-off when requested
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b1;
			hold_cnt  <= 0;
			hold_done <= 1'b0;
		end else if (hold_go && !hold_done) begin
			res_stall <= 1'b1;
			hold_cnt  <= hold_cnt + 1;
			if (hold_cnt == HOLD_LEN - 1)
				hold_done <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// result check
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			board.check_result(res_item);
	end

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(3) - 1;
			3: return {{16{$urandom_range(1) == 1}}, 16'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	// offer one item until accepted
	task automatic send_op(logic [2:0] opc, logic [31:0] a, logic [31:0] b,
		logic [31:0] c, logic [31:0] d);
		in_item_t it;
		it.operation = opc;
		it.op_a = a;
		it.op_b = b;
		it.op_c = c;
		it.op_d = d;
		while ($urandom_range(99) < send_idle_pct) begin
			op_valid <= 1'b0;
			@(posedge clk);
		end
		op_valid <= 1'b1;
		op_item  <= it;
		@(posedge clk);
		while (op_stall)
			@(posedge clk);
		board.note_operation(it);
	endtask

	task automatic send_random();
		logic [2:0] opc;
		logic [31:0] b;
		opc = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
		b = rand_operand();
		if ($urandom_range(15) == 0)
			b = '0;
		send_op(opc, rand_operand(), b, rand_operand(), rand_operand());
	endtask

	task automatic drain();
		op_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		board = new();
		send_idle_pct = 25;
		recv_idle_pct = 49;
		hold_go  = 1'b0;
		arst_n   = 1'b0;
		op_valid = 1'b0;
		op_item  = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every operation, zero and negative divisors
		send_op(OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0);
		send_op(OP_MUL, 32'h8000_0000, 32'h8000_0000, 0, 0);
		send_op(OP_MUL, 32'hffff_8000, 32'h0000_0001, 0, 0);
		send_op(OP_MUL, 32'h0001_8000, 32'hfffe_0000, 0, 0);
		send_op(OP_DIV, 32'h0001_0000, 32'h0003_0000, 0, 0);
		send_op(OP_DIV, 32'h8000_0000, 32'hffff_ffff, 0, 0);
		send_op(OP_DIV, 32'h1234_5678, 32'h0000_0000, 0, 0);
		send_op(OP_DIV, 32'hffff_0000, 32'h0001_0000, 0, 0);
		send_op(OP_DOT, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_op(OP_DOT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_op(OP_DOT, 32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0001);
		send_op(OP_DOT, 32'h0000_8000, 32'h0000_8000, 32'hffff_8000, 32'h0000_8000);
		send_op(OP_RDIV, 32'h0000_0001, 32'h0000_0003, 0, 0);
		send_op(OP_RDIV, 32'hffff_ffff, 32'h0000_0003, 0, 0);
		send_op(OP_RDIV, 32'h0000_0005, 32'hffff_fffd, 0, 0);
		send_op(OP_RDIV, 32'h8000_0000, 32'h0000_0001, 0, 0);
		send_op(OP_RDIV, 32'h0000_0007, 32'h0000_0000, 0, 0);
		send_op(OP_DIV256, 32'h0000_0001, 32'h0000_0001, 0, 0);
		send_op(OP_DIV256, 32'h8000_0000, 32'h7fff_ffff, 0, 0);
		send_op(OP_DIV256, 32'hffff_ffff, 32'h0000_0000, 0, 0);
		send_op(OP_DIV256, 32'h0000_0080, 32'hffff_ffff, 0, 0);
		send_op(3'd5, 32'h7fff_ffff, 32'h0000_0001, 0, 0);
		send_op(3'd7, 32'h8000_0000, 32'h0000_0000, 0, 0);

		// sender pauses until every result is back
		drain();

		// long receiver hold-off while items keep coming
		hold_go <= 1'b1;
		repeat (150) send_random();

		repeat (300) send_random();
		send_idle_pct = 49;
		recv_idle_pct = 25;
		repeat (420) send_random();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (420) send_random();

		drain();
		repeat (LATENCY + 10) @(posedge clk);
		if (board.n_fail == 0 && board.pending.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
